/* rtl/rlgbe_pkg.sv */
// shared types and constants for the rgb led gamma bit encoder
`timescale 1ns / 1ps
`default_nettype none
package rlgbe_pkg;

  localparam int unsigned SlotsPerPixel = 24;
  localparam int unsigned ChanWidth     = 8;
  localparam int unsigned PixelBits     = 3 * ChanWidth;
  localparam int unsigned GammaDepth    = 256;
  localparam int unsigned SlotCntWidth  = 5;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_GAP   = 2'd1,
    OP_TABLE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_CODE_ONE     = 2'd0,
    REG_CODE_ZERO    = 2'd1,
    REG_GAMMA_ENABLE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] compare_value;
    logic       last_of_run;
  } out_beat_t;

  // one run for the serializer: a pixel (green, red, blue msb first) or a gap
  typedef struct packed {
    logic                 is_pixel;
    logic [PixelBits-1:0] bits;
  } run_cmd_t;

  typedef struct packed {
    logic [7:0] code_one;
    logic [7:0] code_zero;
    logic       gamma_enable;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/rlgbe_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rlgbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/rlgbe_front.sv */
// front end: accepts items, writes the gamma table, looks up channels, queues runs
`timescale 1ns / 1ps
`default_nettype none
module rlgbe_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rlgbe_pkg::in_beat_t in_beat,
  input  wire logic                gamma_enable,
  input  wire logic                q_full,
  output logic                     q_push,
  output rlgbe_pkg::run_cmd_t      q_data
);
  import rlgbe_pkg::*;

  typedef enum logic {
    F_IDLE,
    F_LOOK
  } front_state_t;

  front_state_t state;
  logic [1:0] look_cnt;
  logic [7:0] red_q;
  logic [7:0] blue_q;
  logic [7:0] green_c;
  logic [7:0] red_c;
  logic       acc;
  logic       ram_we;
  logic [7:0] ram_raddr;
  logic [7:0] ram_rdata;

  assign in_stall = (state != F_IDLE) || q_full;
  assign acc      = in_valid && !in_stall;
  assign ram_we   = acc && (in_beat.opcode == OP_TABLE);

  // green is read straight off the input beat, red and blue follow
  always_comb begin
    if (state == F_IDLE) begin
      ram_raddr = in_beat.green;
    end else if (look_cnt == 2'd0) begin
      ram_raddr = red_q;
    end else begin
      ram_raddr = blue_q;
    end
  end

  rlgbe_ram #(
    .WIDTH(ChanWidth),
    .DEPTH(GammaDepth)
  ) u_gamma (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_beat.table_index),
    .wdata(in_beat.table_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    q_push = 1'b0;
    q_data = '{is_pixel: 1'b1, bits: {in_beat.green, in_beat.red, in_beat.blue}};
    if (state == F_LOOK) begin
      q_push = (look_cnt == 2'd2);
      q_data = '{is_pixel: 1'b1, bits: {green_c, red_c, ram_rdata}};
    end else if (acc) begin
      if (in_beat.opcode == OP_PIXEL) begin
        q_push = !gamma_enable;
      end else if (in_beat.opcode == OP_GAP) begin
        q_push = 1'b1;
        q_data.is_pixel = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      look_cnt <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (acc && (in_beat.opcode == OP_PIXEL) && gamma_enable) begin
            state    <= F_LOOK;
            look_cnt <= 2'd0;
          end
        end
        F_LOOK: begin
          look_cnt <= look_cnt + 2'd1;
          if (look_cnt == 2'd2) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
    if (acc) begin
      red_q  <= in_beat.red;
      blue_q <= in_beat.blue;
    end
    if (state == F_LOOK && look_cnt == 2'd0) begin
      green_c <= ram_rdata;
    end
    if (state == F_LOOK && look_cnt == 2'd1) begin
      red_c <= ram_rdata;
    end
  end

endmodule
`default_nettype wire

/* rtl/rlgbe_queue.sv */
// two entry run queue between the front end and the serializer
`timescale 1ns / 1ps
`default_nettype none
module rlgbe_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rlgbe_pkg::run_cmd_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output rlgbe_pkg::run_cmd_t      head_data
);
  import rlgbe_pkg::*;

  run_cmd_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/rlgbe_back.sv */
// serializer: turns queued runs into one compare value beat per cycle while out_stall is low
`timescale 1ns / 1ps
`default_nettype none
module rlgbe_back #(
  parameter int unsigned RESET_SLOTS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire rlgbe_pkg::run_cmd_t head_data,
  output logic                     pop,
  input  wire logic [7:0]          code_one,
  input  wire logic [7:0]          code_zero,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rlgbe_pkg::out_beat_t     out_beat
);
  import rlgbe_pkg::*;

  // gap length clipped to one item's result limit, never below one
  localparam int unsigned GapSlots = (RESET_SLOTS > SlotsPerPixel) ? SlotsPerPixel :
                                     ((RESET_SLOTS == 0) ? 1 : RESET_SLOTS);
  localparam logic [SlotCntWidth-1:0] PixelLast = SlotCntWidth'(SlotsPerPixel - 1);
  localparam logic [SlotCntWidth-1:0] GapLast   = SlotCntWidth'(GapSlots - 1);

  logic                    busy;
  logic                    is_pixel;
  logic [PixelBits-1:0]    shift;
  logic [SlotCntWidth-1:0] slot;
  logic                    advance;
  logic                    src_pixel;
  logic [PixelBits-1:0]    src_bits;
  logic [SlotCntWidth-1:0] src_slot;
  logic                    src_last;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !busy && head_valid;

  // current run if one is going, else the queue head starts at slot zero
  always_comb begin
    if (busy) begin
      src_pixel = is_pixel;
      src_bits  = shift;
      src_slot  = slot;
    end else begin
      src_pixel = head_data.is_pixel;
      src_bits  = head_data.bits;
      src_slot  = '0;
    end
    src_last = src_pixel ? (src_slot == PixelLast) : (src_slot == GapLast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy || head_valid;
      if (busy || head_valid) begin
        busy <= !src_last;
      end
    end
    if (advance && (busy || head_valid)) begin
      is_pixel               <= src_pixel;
      shift                  <= {src_bits[PixelBits-2:0], 1'b0};
      slot                   <= src_slot + SlotCntWidth'(1);
      out_beat.last_of_run   <= src_last;
      if (!src_pixel) begin
        out_beat.compare_value <= 8'd0;
      end else if (src_bits[PixelBits-1]) begin
        out_beat.compare_value <= code_one;
      end else begin
        out_beat.compare_value <= code_zero;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rgb_led_gamma_bit_encoder.sv */
// top level of the rgb led gamma bit encoder
//
//  channel  | direction | handshake             | beat
//  ---------+-----------+-----------------------+---------------------------------
//  in       | in        | in_valid / in_stall   | opcode, rgb, gamma table write
//  out      | out       | out_valid / out_stall | compare_value, last_of_run
//  cfg      | in        | cfg_we                | cfg_index, cfg_data
//
// a pixel gives 24 beats and a gap max(1, min(RESET_SLOTS, 24)) beats, one per cycle from the
// serializer while out_stall is low.
// a gamma lookup holds the front end in F_LOOK (three reads through one ram port);
// table writes and raw pixels are taken at once when the front end is idle and the 2 entry queue has room.
// synchronous reset clears control and loads register defaults; the gamma table
// is not cleared. out_stall holds the output register and backs up into the queue.
`timescale 1ns / 1ps
`default_nettype none
module rgb_led_gamma_bit_encoder #(
  parameter int unsigned RESET_SLOTS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rlgbe_pkg::in_beat_t  in_beat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rlgbe_pkg::out_beat_t      out_beat,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data
);
  import rlgbe_pkg::*;

  cfg_t     cfg;
  logic     q_push;
  run_cmd_t q_push_data;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;
  run_cmd_t q_head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_one     <= 8'd60;
      cfg.code_zero    <= 8'd30;
      cfg.gamma_enable <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_CODE_ONE) begin
        cfg.code_one <= cfg_data;
      end else if (cfg_index == REG_CODE_ZERO) begin
        cfg.code_zero <= cfg_data;
      end else if (cfg_index == REG_GAMMA_ENABLE) begin
        cfg.gamma_enable <= cfg_data[0];
      end
    end
  end

  rlgbe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .gamma_enable(cfg.gamma_enable),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  rlgbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (q_head_data)
  );

  rlgbe_back #(
    .RESET_SLOTS(RESET_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head_data (q_head_data),
    .pop       (q_pop),
    .code_one  (cfg.code_one),
    .code_zero (cfg.code_zero),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

/* verif/rgb_led_gamma_bit_encoder_test.sv */
// self-checking testbench for the rgb led gamma bit encoder
`timescale 1ns / 1ps
module rgb_led_gamma_bit_encoder_test;
  import rlgbe_pkg::*;

  localparam int unsigned GapSlots = 24;
  localparam int unsigned GapRun =
      (GapSlots > SlotsPerPixel) ? SlotsPerPixel : ((GapSlots == 0) ? 1 : GapSlots);
  localparam int SettleCycles = 16;
  localparam int IdleLimit = 2000;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_beat_t in_beat;
  logic out_valid;
  logic out_stall;
  out_beat_t out_beat;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  rgb_led_gamma_bit_encoder #(
    .RESET_SLOTS(GapSlots)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block: registers, gamma table and pending slots
  cfg_t cfg_shadow;
  logic [7:0] gamma_shadow [GammaDepth];
  bit [GammaDepth-1:0] gamma_written;
  logic [7:0] written_idx [$];
  out_beat_t expected_slots [$];

  int max_in_gap = 9;
  int max_out_gap = 9;
  int items_sent = 0;
  int slots_checked = 0;
  int errors = 0;
  int quiet_cycles = 0;
  out_beat_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] corrected(input logic [7:0] v);
    return cfg_shadow.gamma_enable ? gamma_shadow[v] : v;
  endfunction

  // expected slots for one accepted input beat
  function automatic void encode_beat(input in_beat_t b);
    logic [7:0] chan [3];
    out_beat_t s;
    int k;
    case (b.opcode)
      OP_PIXEL: begin
        chan[0] = corrected(b.green);
        chan[1] = corrected(b.red);
        chan[2] = corrected(b.blue);
        k = 0;
        for (int c = 0; c < 3; c++) begin
          for (int i = 7; i >= 0; i--) begin
            s.compare_value = chan[c][i] ? cfg_shadow.code_one : cfg_shadow.code_zero;
            s.last_of_run = (k == int'(SlotsPerPixel) - 1);
            expected_slots.push_back(s);
            k++;
          end
        end
      end
      OP_GAP: begin
        for (int i = 0; i < int'(GapRun); i++) begin
          s.compare_value = '0;
          s.last_of_run = (i == int'(GapRun) - 1);
          expected_slots.push_back(s);
        end
      end
      OP_TABLE: begin
        gamma_shadow[b.table_index] = b.table_value;
        if (!gamma_written[b.table_index]) begin
          gamma_written[b.table_index] = 1'b1;
          written_idx.push_back(b.table_index);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_beat_t pixel_beat(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] bl);
    in_beat_t b;
    b.opcode = OP_PIXEL;
    b.red = r;
    b.green = g;
    b.blue = bl;
    b.table_index = 8'($urandom);
    b.table_value = 8'($urandom);
    return b;
  endfunction

  function automatic in_beat_t table_beat(input logic [7:0] idx, input logic [7:0] val);
    in_beat_t b;
    b = pixel_beat(8'($urandom), 8'($urandom), 8'($urandom));
    b.opcode = OP_TABLE;
    b.table_index = idx;
    b.table_value = val;
    return b;
  endfunction

  // mostly pixels; with gamma on, channels only hit entries already written
  function automatic in_beat_t make_item(input bit gamma_on);
    in_beat_t b;
    int pick;
    b = table_beat(8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      b.opcode = OP_PIXEL;
      if (gamma_on) begin
        if (written_idx.size() == 0) begin
          b.opcode = OP_TABLE;
        end else begin
          b.red = written_idx[$urandom_range(0, written_idx.size() - 1)];
          b.green = written_idx[$urandom_range(0, written_idx.size() - 1)];
          b.blue = written_idx[$urandom_range(0, written_idx.size() - 1)];
        end
      end
    end else if (pick < 72) begin
      b.opcode = OP_GAP;
    end else if (pick < 92) begin
      b.opcode = OP_TABLE;
    end else begin
      b.opcode = OpUnused;
    end
    return b;
  endfunction

  task automatic send_item(input in_beat_t b);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_beat <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    encode_beat(b);
    items_sent++;
  endtask

  // stop sending and wait for every pending slot, then let table writes settle
  task automatic wait_results_done(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_slots.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] one, input logic [7:0] zero,
                            input bit gamma_on);
    wait_results_done(SettleCycles);
    cfg_we <= 1'b1;
    cfg_index <= REG_CODE_ONE;
    cfg_data <= one;
    @(posedge clk);
    cfg_index <= REG_CODE_ZERO;
    cfg_data <= zero;
    @(posedge clk);
    // upper bits must be masked off by the block
    cfg_index <= REG_GAMMA_ENABLE;
    cfg_data <= {7'($urandom), gamma_on};
    @(posedge clk);
    cfg_index <= RegUnused;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_shadow.code_one = one;
    cfg_shadow.code_zero = zero;
    cfg_shadow.gamma_enable = gamma_on;
  endtask

  // register defaults after reset, gamma on
  task automatic test_reset_defaults();
    send_item(table_beat(8'h00, 8'hFF));
    send_item(table_beat(8'hFF, 8'h00));
    send_item(table_beat(8'h5A, 8'hA5));
    send_item(table_beat(8'hA5, 8'h5A));
    send_item(pixel_beat(8'h00, 8'hFF, 8'h5A));
    send_item(pixel_beat(8'hA5, 8'h00, 8'hFF));
    send_item(make_item(1'b1));
    send_item(table_beat(8'h00, 8'hFF));
  endtask

  task automatic test_directed_extremes();
    in_beat_t b;
    set_config(8'hFF, 8'h00, 1'b0);
    send_item(pixel_beat(8'hFF, 8'h00, 8'hFF));
    send_item(pixel_beat(8'h00, 8'hFF, 8'h00));
    b = pixel_beat(8'hFF, 8'hFF, 8'hFF);
    b.opcode = OpUnused;
    send_item(b);
    b.opcode = OP_GAP;
    send_item(b);
    send_item(table_beat(8'h12, 8'h34));
    set_config(8'h00, 8'hFF, 1'b1);
    send_item(pixel_beat(8'h5A, 8'hA5, 8'h00));
    send_item(pixel_beat(8'hFF, 8'hFF, 8'hFF));
    // table write followed at once by a pixel that reads the new entry
    max_in_gap = 0;
    send_item(table_beat(8'h3C, 8'hC3));
    send_item(pixel_beat(8'h3C, 8'h3C, 8'h3C));
    max_in_gap = 9;
    set_config(8'h81, 8'h81, 1'b0);
    send_item(pixel_beat(8'($urandom), 8'($urandom), 8'($urandom)));
    b.opcode = OP_GAP;
    send_item(b);
  endtask

  task automatic test_random_raw();
    set_config(8'($urandom), 8'($urandom), 1'b0);
    repeat (40) send_item(make_item(1'b0));
    set_config(8'h00, 8'h00, 1'b0);
    repeat (40) send_item(make_item(1'b0));
  endtask

  task automatic test_random_gamma();
    set_config(8'($urandom), 8'($urandom), 1'b1);
    repeat (8) send_item(table_beat(8'($urandom), 8'($urandom)));
    repeat (45) send_item(make_item(1'b1));
    set_config(8'($urandom), 8'($urandom), 1'b1);
    repeat (45) send_item(make_item(1'b1));
  endtask

  task automatic test_back_to_back();
    set_config(8'd60, 8'd30, 1'b1);
    max_in_gap = 0;
    max_out_gap = 0;
    repeat (40) send_item(make_item(1'b1));
    max_in_gap = 9;
    max_out_gap = 9;
  endtask

  task automatic test_pause_until_empty();
    set_config(8'hFF, 8'hFF, 1'b0);
    for (int i = 0; i < 24; i++) begin
      send_item(make_item(1'b0));
      if (i % 4 == 3) begin
        wait_results_done(1);
      end
    end
  endtask

  // receiver: random stall before each beat
  initial begin : out_side
    int n;
    forever begin
      n = $urandom_range(0, max_out_gap);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_slots.size() == 0) begin
        $error("unexpected beat: compare_value %0d last_of_run %0b",
               out_beat.compare_value, out_beat.last_of_run);
        errors++;
      end else begin
        want = expected_slots.pop_front();
        if (out_beat.compare_value !== want.compare_value) begin
          $error("compare_value expected %0d actual %0d",
                 want.compare_value, out_beat.compare_value);
          errors++;
        end
        if (out_beat.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0b actual %0b",
                 want.last_of_run, out_beat.last_of_run);
          errors++;
        end
        slots_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no beat moved for %0d cycles, %0d slots pending",
               quiet_cycles, expected_slots.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cfg_shadow.code_one = 8'd60;
    cfg_shadow.code_zero = 8'd30;
    cfg_shadow.gamma_enable = 1'b1;
    gamma_written = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_beat <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_extremes();
    test_random_raw();
    test_random_gamma();
    test_back_to_back();
    test_pause_until_empty();
    wait_results_done(SettleCycles);

    $display("covered %0d input beats (pixels, gaps, table writes, unused opcode)",
             items_sent);
    $display("and %0d output slots across raw, gamma and extreme code settings",
             slots_checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
